>>> src/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg: shared types and tables for the character LCD write sequencer
// Item structs, request kinds, classified operations and the init step ROM.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // request kinds on the input channel
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_INIT     = 3'd1;
  localparam logic [2:0] KIND_CMD      = 3'd2;
  localparam logic [2:0] KIND_CHAR     = 3'd3;
  localparam logic [2:0] KIND_CURSOR   = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;
  localparam logic [2:0] KIND_SHIFT_R  = 3'd6;
  localparam logic [2:0] KIND_SHIFT_L  = 3'd7;

  // LCD command bytes
  localparam logic [7:0] LCD_FUNC_SET  = 8'h30;
  localparam logic [7:0] LCD_FUNC_8B2L = 8'h38;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_ROW1_BASE = 8'h80;
  localparam logic [7:0] LCD_ROW2_BASE = 8'hC0;
  localparam logic [7:0] LCD_SHIFT_R   = 8'h1C;
  localparam logic [7:0] LCD_SHIFT_L   = 8'h18;

  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_TWO = 2'd2;

  // sequencer step codes
  localparam int         STEP_W        = 5;
  localparam logic [4:0] STEP_IDLE     = 5'd0;
  localparam logic [4:0] STEP_XFER_HI  = 5'd1;
  localparam logic [4:0] STEP_XFER_LO  = 5'd2;
  localparam logic [4:0] STEP_INIT_WT  = 5'd3;
  localparam logic [4:0] STEP_INIT_1ST = 5'd4;
  localparam logic [4:0] STEP_LAST     = 5'd20;

  localparam logic [15:0] TPM_RESET    = 16'd1000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [7:0] data_bus;
    logic       busy_res;
    logic       accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_INIT = 2'd1,
    OP_XFER = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t        op;
    logic       rs;
    logic [7:0] data;
  } op_item_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_HIGH = 2'd1,
    ACT_LOW  = 2'd2
  } act_t;

  function automatic act_t step_action(input logic [4:0] s);
    act_t a;
    case (s)
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd15, 5'd17, 5'd19: a = ACT_HIGH;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd16, 5'd18, 5'd20: a = ACT_LOW;
      default:                                             a = ACT_NONE;
    endcase
    return a;
  endfunction

  function automatic logic [4:0] step_ms(input logic [4:0] s);
    logic [4:0] m;
    case (s)
      STEP_IDLE:    m = 5'd0;
      STEP_INIT_WT: m = 5'd20;
      5'd6:         m = 5'd5;
      5'd12:        m = 5'd10;
      default:      m = 5'd1;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] step_byte(input logic [4:0] s);
    logic [7:0] b;
    case (s)
      5'd4, 5'd7, 5'd10: b = LCD_FUNC_SET;
      5'd13:             b = LCD_FUNC_8B2L;
      5'd15:             b = LCD_DISP_ON;
      5'd17:             b = LCD_CLEAR;
      5'd19:             b = LCD_ENTRY;
      default:           b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] next_step(input logic [4:0] s);
    logic [4:0] n;
    if (s == STEP_XFER_LO || s >= STEP_LAST) begin
      n = STEP_IDLE;
    end else begin
      n = s + 5'd1;
    end
    return n;
  endfunction

endpackage

>>> src/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front: request classifier
// Turns a raw request into a tick, init, single transfer or no-op.
// ----------------------------------------------------------------------------
module lcdws_front import lcdws_pkg::*; (
  input  in_item_t item,
  output op_item_t op_item
);

  always_comb begin
    op_item.op   = OP_XFER;
    op_item.rs   = 1'b0;
    op_item.data = 8'h00;
    case (item.kind)
      KIND_TICK: op_item.op = OP_TICK;
      KIND_INIT: op_item.op = OP_INIT;
      KIND_CMD:  op_item.data = item.value;
      KIND_CHAR: begin
        op_item.rs   = 1'b1;
        op_item.data = item.value;
      end
      KIND_CURSOR: begin
        // rows other than one and two are dropped
        if (item.row == ROW_ONE) begin
          op_item.data = LCD_ROW1_BASE + {2'b00, item.column};
        end else if (item.row == ROW_TWO) begin
          op_item.data = LCD_ROW2_BASE + {2'b00, item.column};
        end else begin
          op_item.op = OP_NOP;
        end
      end
      KIND_CLEAR:   op_item.data = LCD_CLEAR;
      KIND_SHIFT_R: op_item.data = LCD_SHIFT_R;
      KIND_SHIFT_L: op_item.data = LCD_SHIFT_L;
      default:      op_item.op = OP_NOP;
    endcase
  end

endmodule

>>> src/lcdws_queue.sv
// ----------------------------------------------------------------------------
// lcdws_queue: two-entry operation queue
// Decouples the classifier from the pin sequencer.
// ----------------------------------------------------------------------------
module lcdws_queue import lcdws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  op_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output op_item_t head
);

  op_item_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

>>> src/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back: pin sequencer
// Runs transfers and the init sequence, counts ticks and registers results.
// ----------------------------------------------------------------------------
module lcdws_back import lcdws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  op_item_t  op_item,
  output logic      op_pop,
  input  logic      cfg_we,
  input  logic [15:0] cfg_tpm,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [15:0] tpm_r;
  logic [4:0]  step_r, step_nxt;
  logic [4:0]  ms_r, ms_nxt;
  logic [15:0] tc_r, tc_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        rs_r, rs_nxt;
  logic        en_r, en_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic        busy, enter, acc;
  logic [4:0]  ns, ms_dec;
  logic [15:0] limit, tc_inc;

  assign op_pop    = op_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    busy     = (step_r != STEP_IDLE);
    limit    = (tpm_r == 16'd0) ? 16'd1 : tpm_r;
    tc_inc   = tc_r + 16'd1;
    ms_dec   = (ms_r != 5'd0) ? ms_r - 5'd1 : 5'd0;
    step_nxt = step_r;
    ms_nxt   = ms_r;
    tc_nxt   = tc_r;
    pend_nxt = pend_r;
    rs_nxt   = rs_r;
    en_nxt   = en_r;
    data_nxt = data_r;
    enter    = 1'b0;
    ns       = STEP_IDLE;
    acc      = 1'b0;

    case (op_item.op)
      OP_TICK: begin
        if (busy) begin
          if (tc_inc >= limit) begin
            tc_nxt = 16'd0;
            ms_nxt = ms_dec;
            if (ms_dec == 5'd0) begin
              enter = 1'b1;
              ns    = next_step(step_r);
            end
          end else begin
            tc_nxt = tc_inc;
          end
        end
      end
      OP_INIT: begin
        if (!busy) begin
          acc    = 1'b1;
          rs_nxt = 1'b0;
          en_nxt = 1'b0;
          enter  = 1'b1;
          ns     = STEP_INIT_WT;
        end
      end
      OP_XFER: begin
        if (!busy) begin
          acc      = 1'b1;
          rs_nxt   = op_item.rs;
          pend_nxt = op_item.data;
          enter    = 1'b1;
          ns       = STEP_XFER_HI;
        end
      end
      default: acc = 1'b0;
    endcase

    // step entry: load duration, drive strobe and bus per step ROM
    if (enter) begin
      step_nxt = ns;
      ms_nxt   = step_ms(ns);
      tc_nxt   = 16'd0;
      if (step_action(ns) == ACT_HIGH) begin
        if (ns >= STEP_INIT_1ST) begin
          pend_nxt = step_byte(ns);
          rs_nxt   = 1'b0;
        end
        data_nxt = pend_nxt;
        en_nxt   = 1'b1;
      end else if (step_action(ns) == ACT_LOW) begin
        en_nxt = 1'b0;
      end
    end

    out_nxt.rs_pin     = rs_nxt;
    out_nxt.enable_pin = en_nxt;
    out_nxt.data_bus   = data_nxt;
    out_nxt.busy_res   = (step_nxt != STEP_IDLE);
    out_nxt.accepted   = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r       <= TPM_RESET;
      step_r      <= STEP_IDLE;
      ms_r        <= 5'd0;
      tc_r        <= 16'd0;
      pend_r      <= 8'h00;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      data_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpm_r <= cfg_tpm;
      end
      if (op_pop) begin
        step_r <= step_nxt;
        ms_r   <= ms_nxt;
        tc_r   <= tc_nxt;
        pend_r <= pend_nxt;
        rs_r   <= rs_nxt;
        en_r   <= en_nxt;
        data_r <= data_nxt;
      end
      if (op_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      out_r <= out_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST) else $error("step code out of range");
  a_en_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |-> step_r != STEP_IDLE) else $error("E high while idle");
  a_ms_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_IDLE) == (ms_r == 5'd0)) else $error("ms count mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule

>>> src/char_lcd_8bit_write_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_8bit_write_sequencer_top: 8-bit character LCD write sequencer
// Drives RS, E and D0..D7 from a stream of tick and request items.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake         payload
//  in_      in   in_valid/in_stall  in_item_t  (kind, value, row, column)
//  out_     out  out_valid/out_stall out_item_t (rs, E, data, busy, accepted)
//  cfg_     in   cfg_valid/cfg_ready cfg_data  (ticks per millisecond)
//
//  One item per clock sustained while out_stall is low; each item yields one
//  result transfer via the queue stage, then the result register.
//  The two-entry queue lets input keep flowing while a result is stalled;
//  in_stall rises only when the queue is full.
//  Synchronous active-low reset: sequencer idle, ticks_per_ms 1000.
//  cfg_ready is always high; writes are expected only while idle.
//
module char_lcd_8bit_write_sequencer_top import lcdws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // ticks_per_ms write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  op_item_t cls_item;   // classified request from the front
  op_item_t q_head;     // oldest queued operation
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     in_push;

  assign in_stall  = q_full;
  assign in_push   = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  // front: classify raw requests
  lcdws_front u_front (
    .item    (in_data),
    .op_item (cls_item)
  );

  // short queue between classifier and sequencer
  lcdws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: pin sequencer with result register
  lcdws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_not_empty),
    .op_item   (q_head),
    .op_pop    (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_tpm   (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
